// ===== rtl/core/mtok_pkg.sv =====
`timescale 1ns / 1ps
package mtok_pkg;

  localparam int CHAR_W = 16;
  localparam int DOC_W  = 15;
  localparam int MIN_W  = 6;

  localparam int MAX_WORD_LEN_DEF = 63;

  localparam logic [MIN_W-1:0] MIN_WORD_LEN_RESET = 6'd2;

  localparam logic [CHAR_W-1:0] CH_LT    = 16'h003C;
  localparam logic [CHAR_W-1:0] CH_AMP   = 16'h0026;
  localparam logic [CHAR_W-1:0] CH_GT    = 16'h003E;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 16'h003B;
  localparam logic [CHAR_W-1:0] CH_UNDER = 16'h005F;
  localparam logic [CHAR_W-1:0] CH_A     = 16'h0061;
  localparam logic [CHAR_W-1:0] CH_B     = 16'h0062;
  localparam logic [CHAR_W-1:0] CH_M     = 16'h006D;
  localparam logic [CHAR_W-1:0] CH_N     = 16'h006E;
  localparam logic [CHAR_W-1:0] CH_P     = 16'h0070;
  localparam logic [CHAR_W-1:0] CH_S     = 16'h0073;

endpackage

// ===== rtl/core/markup_text_word_tokenizer.sv =====
`timescale 1ns / 1ps
// Markup-aware word tokenizer. Text arrives one 16-bit code unit per item; markup from
// '<' or '&' through the next '>' or ';' is skipped, and runs of letters, digits and '_'
// (up to MAX_WORD_LEN) form words. A word that ends and is at least min_word_length long,
// and is not "amp" or "nbsp", comes out one character per item with word_last on its final
// character and the document number of the item that ended it. The front takes one text
// item per cycle into one of two word buffers; a finished word is queued and the back
// replays it from buffer memory one character at a time (a registered memory read, then the
// output register; no new read while one is pending). When the front finishes a word while
// the other buffer is still being replayed, it stalls until that replay has issued its last
// read. min_word_length resets to 2 and is written via cfg_valid/cfg_ready (always ready).
module markup_text_word_tokenizer #(
  parameter int MAX_WORD_LEN = mtok_pkg::MAX_WORD_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        text_valid,
  output logic                        text_stall,
  input  logic [mtok_pkg::CHAR_W-1:0] char_code,
  input  logic                        is_alnum,
  input  logic [mtok_pkg::DOC_W-1:0]  doc_number,
  input  logic                        end_of_text,
  output logic                        word_valid,
  input  logic                        word_stall,
  output logic [mtok_pkg::CHAR_W-1:0] word_char,
  output logic [mtok_pkg::DOC_W-1:0]  word_doc,
  output logic                        word_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mtok_pkg::MIN_W-1:0]  min_word_length
);

  localparam int AW    = $clog2(MAX_WORD_LEN);
  localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
  localparam int CMD_W = 1 + LEN_W + mtok_pkg::DOC_W;

  logic             wr_en;
  logic [AW:0]      wr_addr;
  logic [mtok_pkg::CHAR_W-1:0] wr_data;
  logic             push;
  logic [CMD_W-1:0] push_data;
  logic             pop;
  logic             head_valid;
  logic [CMD_W-1:0] head_data;
  logic             rel_valid;
  logic             rel_bank;

  assign cfg_ready = 1'b1;

  mtok_front #(
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .text_valid      (text_valid),
    .text_stall      (text_stall),
    .char_code       (char_code),
    .is_alnum        (is_alnum),
    .doc_number      (doc_number),
    .end_of_text     (end_of_text),
    .cfg_valid       (cfg_valid & cfg_ready),
    .min_word_length (min_word_length),
    .rel_valid       (rel_valid),
    .rel_bank        (rel_bank),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .push            (push),
    .push_data       (push_data)
  );

  mtok_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  mtok_back #(
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .rel_valid  (rel_valid),
    .rel_bank   (rel_bank),
    .word_valid (word_valid),
    .word_stall (word_stall),
    .word_char  (word_char),
    .word_doc   (word_doc),
    .word_last  (word_last)
  );

endmodule

// ===== rtl/core/mtok_queue.sv =====
`timescale 1ns / 1ps
module mtok_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign head_valid = (count != 2'd0);
  assign head_data  = slots[rptr];

endmodule

// ===== rtl/core/mtok_front.sv =====
`timescale 1ns / 1ps
module mtok_front #(
  parameter int MAX_WORD_LEN = mtok_pkg::MAX_WORD_LEN_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        text_valid,
  output logic                                        text_stall,
  input  logic [mtok_pkg::CHAR_W-1:0]                 char_code,
  input  logic                                        is_alnum,
  input  logic [mtok_pkg::DOC_W-1:0]                  doc_number,
  input  logic                                        end_of_text,
  input  logic                                        cfg_valid,
  input  logic [mtok_pkg::MIN_W-1:0]                  min_word_length,
  input  logic                                        rel_valid,
  input  logic                                        rel_bank,
  output logic                                        wr_en,
  output logic [$clog2(MAX_WORD_LEN):0]               wr_addr,
  output logic [mtok_pkg::CHAR_W-1:0]                 wr_data,
  output logic                                        push,
  output logic [$clog2(MAX_WORD_LEN+1)+mtok_pkg::DOC_W:0] push_data
);

  localparam int AW    = $clog2(MAX_WORD_LEN);
  localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
  localparam int CMP_W = (LEN_W > mtok_pkg::MIN_W) ? LEN_W : mtok_pkg::MIN_W;

  typedef struct packed {
    logic                       bank;
    logic [LEN_W-1:0]           len;
    logic [mtok_pkg::DOC_W-1:0] doc;
  } word_cmd_t;

  logic [mtok_pkg::MIN_W-1:0] min_len;
  logic                       in_markup;
  logic [LEN_W-1:0]           len;
  logic                       cur;
  logic [1:0]                 busy;
  logic                       amp_m;
  logic                       nbsp_m;

  logic             accept;
  logic             is_open;
  logic             is_close;
  logic             word_ok;
  logic             do_write;
  logic             do_flush;
  logic [LEN_W-1:0] len_after;
  logic             amp_after;
  logic             nbsp_after;
  logic             amp_hit;
  logic             nbsp_hit;
  logic             qualify;
  logic [1:0]       busy_next;
  word_cmd_t        cmd;

  assign accept = text_valid & ~text_stall;

  assign is_open  = (char_code == mtok_pkg::CH_LT) || (char_code == mtok_pkg::CH_AMP);
  assign is_close = ((char_code == mtok_pkg::CH_GT) || (char_code == mtok_pkg::CH_SEMI))
                    && in_markup;
  assign word_ok  = (is_alnum || (char_code == mtok_pkg::CH_UNDER))
                    && (len < LEN_W'(MAX_WORD_LEN));

  assign amp_hit  = ((len == LEN_W'(0)) && (char_code == mtok_pkg::CH_A))
                 || ((len == LEN_W'(1)) && (char_code == mtok_pkg::CH_M))
                 || ((len == LEN_W'(2)) && (char_code == mtok_pkg::CH_P));
  assign nbsp_hit = ((len == LEN_W'(0)) && (char_code == mtok_pkg::CH_N))
                 || ((len == LEN_W'(1)) && (char_code == mtok_pkg::CH_B))
                 || ((len == LEN_W'(2)) && (char_code == mtok_pkg::CH_S))
                 || ((len == LEN_W'(3)) && (char_code == mtok_pkg::CH_P));

  always_comb begin
    do_write = 1'b0;
    do_flush = end_of_text;
    if (is_open) begin
      do_flush = 1'b1;
    end else if (is_close) begin
      do_flush = end_of_text;
    end else if (!in_markup) begin
      if (word_ok) begin
        do_write = 1'b1;
      end else begin
        do_flush = 1'b1;
      end
    end
  end

  assign len_after  = do_write ? (len + LEN_W'(1)) : len;
  assign amp_after  = do_write ? (amp_m & amp_hit) : amp_m;
  assign nbsp_after = do_write ? (nbsp_m & nbsp_hit) : nbsp_m;

  assign qualify = (len_after != LEN_W'(0))
                && (CMP_W'(len_after) >= CMP_W'(min_len))
                && !(amp_after && (len_after == LEN_W'(3)))
                && !(nbsp_after && (len_after == LEN_W'(4)));

  assign text_stall = busy[cur];

  assign wr_en   = accept & do_write;
  assign wr_addr = {cur, len[AW-1:0]};
  assign wr_data = char_code;

  assign push      = accept & do_flush & qualify;
  assign cmd.bank  = cur;
  assign cmd.len   = len_after;
  assign cmd.doc   = doc_number;
  assign push_data = cmd;

  always_comb begin
    busy_next = busy;
    if (rel_valid) begin
      busy_next[rel_bank] = 1'b0;
    end
    if (push) begin
      busy_next[cur] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_len   <= mtok_pkg::MIN_WORD_LEN_RESET;
      in_markup <= 1'b0;
      len       <= '0;
      cur       <= 1'b0;
      busy      <= '0;
      amp_m     <= 1'b1;
      nbsp_m    <= 1'b1;
    end else begin
      busy <= busy_next;
      if (cfg_valid) begin
        min_len <= min_word_length;
      end
      if (accept) begin
        if (end_of_text) begin
          in_markup <= 1'b0;
        end else if (is_open) begin
          in_markup <= 1'b1;
        end else if (is_close) begin
          in_markup <= 1'b0;
        end
        if (do_flush) begin
          len    <= '0;
          amp_m  <= 1'b1;
          nbsp_m <= 1'b1;
        end else begin
          len    <= len_after;
          amp_m  <= amp_after;
          nbsp_m <= nbsp_after;
        end
        if (push) begin
          cur <= ~cur;
        end
      end
    end
  end

endmodule

// ===== rtl/core/mtok_back.sv =====
`timescale 1ns / 1ps
module mtok_back #(
  parameter int MAX_WORD_LEN = mtok_pkg::MAX_WORD_LEN_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            wr_en,
  input  logic [$clog2(MAX_WORD_LEN):0]                   wr_addr,
  input  logic [mtok_pkg::CHAR_W-1:0]                     wr_data,
  input  logic                                            head_valid,
  input  logic [$clog2(MAX_WORD_LEN+1)+mtok_pkg::DOC_W:0] head_data,
  output logic                                            pop,
  output logic                                            rel_valid,
  output logic                                            rel_bank,
  output logic                                            word_valid,
  input  logic                                            word_stall,
  output logic [mtok_pkg::CHAR_W-1:0]                     word_char,
  output logic [mtok_pkg::DOC_W-1:0]                      word_doc,
  output logic                                            word_last
);

  localparam int AW    = $clog2(MAX_WORD_LEN);
  localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
  localparam int DEPTH = 2 * (2 ** AW);

  typedef struct packed {
    logic                       bank;
    logic [LEN_W-1:0]           len;
    logic [mtok_pkg::DOC_W-1:0] doc;
  } word_cmd_t;

  logic [mtok_pkg::CHAR_W-1:0] mem [DEPTH];

  word_cmd_t                   head;
  logic                        run;
  logic                        bank;
  logic [LEN_W-1:0]            len;
  logic [mtok_pkg::DOC_W-1:0]  doc;
  logic [AW-1:0]               idx;
  logic                        rd_pend;
  logic [mtok_pkg::CHAR_W-1:0] rd_data;
  logic [mtok_pkg::DOC_W-1:0]  rd_doc;
  logic                        rd_last;
  logic                        out_valid;
  logic                        issue;
  logic                        is_last;

  assign head    = head_data;
  assign pop     = head_valid & ~run;
  assign issue   = run & ~rd_pend & (~out_valid | ~word_stall);
  assign is_last = ((LEN_W'(idx) + LEN_W'(1)) == len);

  assign rel_valid = issue & is_last;
  assign rel_bank  = bank;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data <= mem[{bank, idx}];
      rd_doc  <= doc;
      rd_last <= is_last;
    end
    if (pop) begin
      bank <= head.bank;
      len  <= head.len;
      doc  <= head.doc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run       <= 1'b0;
      idx       <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (rd_pend) begin
        out_valid <= 1'b1;
      end else if (!word_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        run <= 1'b1;
        idx <= '0;
      end else if (issue) begin
        if (is_last) begin
          run <= 1'b0;
        end
        idx <= idx + AW'(1);
      end
    end
  end

  assign word_valid = out_valid;
  assign word_char  = rd_data;
  assign word_doc   = rd_doc;
  assign word_last  = rd_last;

endmodule

// ===== sim/mtok_word_check.sv =====
`timescale 1ns / 1ps
module mtok_word_check #(
  parameter int MAX_WORD_LEN = mtok_pkg::MAX_WORD_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        text_valid,
  input  logic                        text_stall,
  input  logic [mtok_pkg::CHAR_W-1:0] char_code,
  input  logic                        is_alnum,
  input  logic [mtok_pkg::DOC_W-1:0]  doc_number,
  input  logic                        end_of_text,
  input  logic                        word_valid,
  input  logic                        word_stall,
  input  logic [mtok_pkg::CHAR_W-1:0] word_char,
  input  logic [mtok_pkg::DOC_W-1:0]  word_doc,
  input  logic                        word_last,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [mtok_pkg::MIN_W-1:0]  min_word_length,
  output int                          fail_count,
  output int                          words_pending
);

  typedef logic [mtok_pkg::CHAR_W-1:0] char_t;
  typedef logic [mtok_pkg::DOC_W-1:0]  doc_t;
  typedef logic [mtok_pkg::MIN_W-1:0]  min_t;

  typedef struct packed {
    char_t ch;
    doc_t  doc;
    logic  last;
  } word_beat_t;

  word_beat_t word_beats_q[$];
  min_t       min_len = mtok_pkg::MIN_WORD_LEN_RESET;
  logic       in_markup = 1'b0;
  int         held_len = 0;
  char_t      held_chars [MAX_WORD_LEN];

  initial begin
    fail_count    = 0;
    words_pending = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: word item %s: got %h, want %h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic int release_word(input doc_t doc);
    int n;
    n        = held_len;
    held_len = 0;
    if (n == 0 || n < int'(min_len)) return 0;
    if (n == 3 && held_chars[0] == mtok_pkg::CH_A && held_chars[1] == mtok_pkg::CH_M &&
        held_chars[2] == mtok_pkg::CH_P)
      return 0;
    if (n == 4 && held_chars[0] == mtok_pkg::CH_N && held_chars[1] == mtok_pkg::CH_B &&
        held_chars[2] == mtok_pkg::CH_S && held_chars[3] == mtok_pkg::CH_P)
      return 0;
    for (int k = 0; k < n; k++) word_beats_q.push_back({held_chars[k], doc, k == n - 1});
    return n;
  endfunction

  function automatic void tokenize_char(input char_t c, input logic alnum,
                                        input doc_t doc, input logic eot);
    int emitted;
    emitted = 0;
    if (c == mtok_pkg::CH_LT || c == mtok_pkg::CH_AMP) begin
      in_markup = 1'b1;
      emitted   = release_word(doc);
    end else if ((c == mtok_pkg::CH_GT || c == mtok_pkg::CH_SEMI) && in_markup) begin
      in_markup = 1'b0;
    end else if (!in_markup) begin
      if ((alnum || c == mtok_pkg::CH_UNDER) && held_len < MAX_WORD_LEN) begin
        held_chars[held_len] = c;
        held_len++;
      end else begin
        emitted = release_word(doc);
      end
    end
    if (eot) begin
      if (emitted == 0) emitted = release_word(doc);
      held_len  = 0;
      in_markup = 1'b0;
    end
  endfunction

  always @(posedge clk) begin : watch
    word_beat_t want;
    if (rst) begin
      min_len   = mtok_pkg::MIN_WORD_LEN_RESET;
      in_markup = 1'b0;
      held_len  = 0;
      word_beats_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) min_len = min_word_length;
      if (text_valid && !text_stall) tokenize_char(char_code, is_alnum, doc_number, end_of_text);
      if (word_valid && !word_stall) begin
        if (word_beats_q.size() == 0) begin
          report_mismatch("with nothing expected, char", 32'(word_char), '0);
        end else begin
          want = word_beats_q.pop_front();
          if (word_char !== want.ch)
            report_mismatch("word_char", 32'(word_char), 32'(want.ch));
          if (word_doc !== want.doc)
            report_mismatch("word_doc", 32'(word_doc), 32'(want.doc));
          if (word_last !== want.last)
            report_mismatch("word_last", 32'(word_last), 32'(want.last));
        end
      end
    end
    words_pending <= word_beats_q.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam int IDLE_LIMIT    = 1000;
  localparam int SETTLE_CYCLES = 16;

  typedef logic [mtok_pkg::CHAR_W-1:0] char_t;
  typedef logic [mtok_pkg::DOC_W-1:0]  doc_t;
  typedef logic [mtok_pkg::MIN_W-1:0]  min_t;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_LIGHT, STALL_BURSTY} stall_mode_t;

  logic        clk;
  logic        rst;
  logic        text_valid;
  logic        text_stall;
  char_t       char_code;
  logic        is_alnum;
  doc_t        doc_number;
  logic        end_of_text;
  logic        word_valid;
  logic        word_stall = 1'b0;
  char_t       word_char;
  doc_t        word_doc;
  logic        word_last;
  logic        cfg_valid;
  logic        cfg_ready;
  min_t        min_word_length;

  int          fail_count;
  int          words_pending;
  int          idle_cycles = 0;
  int          burst_left;
  int          stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  doc_t        doc_cur;

  markup_text_word_tokenizer i_dut (.*);

  mtok_word_check i_check (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  word_stall <= 1'b0;
      STALL_HALF:  word_stall <= ($urandom_range(0, 1) == 1);
      STALL_LIGHT: word_stall <= ($urandom_range(0, 7) == 0);
      default:     word_stall <= ((stall_left % 16) < 11);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (text_valid && !text_stall) || (word_valid && !word_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("markup_text_word_tokenizer regression: fail");
        $finish;
      end
    end
  end

  task automatic send_char(input char_t c, input logic alnum, input logic eot);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 24);
      if (gap > 0) begin
        text_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    text_valid  <= 1'b1;
    char_code   <= c;
    is_alnum    <= alnum;
    doc_number  <= doc_cur;
    end_of_text <= eot;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_str(input string s, input bit eot_last);
    char_t c;
    for (int k = 0; k < s.len(); k++) begin
      c = {8'h00, s[k]};
      send_char(c, (c >= "a" && c <= "z") || (c >= "0" && c <= "9"),
                eot_last && k == s.len() - 1);
    end
  endtask

  task automatic send_word(input int len);
    char_t c;
    logic  alnum;
    int    pick;
    for (int k = 0; k < len; k++) begin
      pick  = $urandom_range(0, 19);
      alnum = 1'b1;
      if (pick < 14) c = char_t'(mtok_pkg::CH_A + $urandom_range(0, 25));
      else if (pick < 17) c = char_t'($urandom_range(0, 16'hFFFF));
      else if (pick < 18) c = char_t'(16'h0030 + $urandom_range(0, 9));
      else begin
        c     = mtok_pkg::CH_UNDER;
        alnum = 1'($urandom_range(0, 1));
      end
      send_char(c, alnum, 1'b0);
    end
  endtask

  task automatic send_delim(input logic eot);
    char_t c;
    case ($urandom_range(0, 4))
      0:       c = 16'h0020;
      1:       c = 16'h002E;
      2:       c = mtok_pkg::CH_GT;
      3:       c = mtok_pkg::CH_SEMI;
      default: c = 16'h000A;
    endcase
    send_char(c, 1'b0, eot);
  endtask

  task automatic send_markup();
    send_char(($urandom_range(0, 1) == 1) ? mtok_pkg::CH_LT : mtok_pkg::CH_AMP,
              1'($urandom_range(0, 1)), 1'b0);
    repeat ($urandom_range(0, 5))
      send_char(char_t'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)), 1'b0);
    send_char(($urandom_range(0, 1) == 1) ? mtok_pkg::CH_GT : mtok_pkg::CH_SEMI,
              1'($urandom_range(0, 1)), 1'b0);
  endtask

  task automatic send_random_text(input int n_items);
    int pick;
    int sent;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if ($urandom_range(0, 19) == 0) begin
          pick = $urandom_range(55, 66);
        end else begin
          pick = $urandom_range(1, 8);
        end
        send_word(pick);
        send_delim($urandom_range(0, 9) == 0);
        sent += pick + 1;
      end else if (pick < 57) begin
        send_markup();
        sent += 3;
      end else if (pick < 64) begin
        if ($urandom_range(0, 1) == 1) begin
          send_str("amp", 1'b0);
        end else begin
          send_str("nbsp", 1'b0);
        end
        send_delim(1'b0);
        sent += 4;
      end else if (pick < 74) begin
        send_delim(1'b0);
        sent++;
      end else if (pick < 86) begin
        send_char(char_t'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)), 1'b0);
        sent++;
      end else if (pick < 96) begin
        send_char(char_t'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)), 1'b1);
        doc_cur = doc_t'($urandom_range(0, 16'h7FFF));
        sent++;
      end else begin
        doc_cur = doc_t'($urandom_range(0, 16'h7FFF));
      end
    end
  endtask

  task automatic wait_drained();
    text_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_min_length(input min_t v);
    wait_drained();
    cfg_valid       <= 1'b1;
    min_word_length <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst             = 1'b1;
    text_valid      = 1'b0;
    char_code       = '0;
    is_alnum        = 1'b0;
    doc_number      = '0;
    end_of_text     = 1'b0;
    cfg_valid       = 1'b0;
    min_word_length = mtok_pkg::MIN_WORD_LEN_RESET;
    burst_left      = 0;
    doc_cur         = 15'd1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_str("ab ", 1'b0);
    send_str("x.", 1'b0);
    send_str("amp,", 1'b0);
    send_str("nbsp<", 1'b0);
    send_str("&z>", 1'b0);
    send_str("q_>", 1'b0);
    doc_cur = 15'h7FFF;
    send_char(16'hFFFF, 1'b1, 1'b0);
    send_char(16'h0000, 1'b1, 1'b1);
    doc_cur = 15'h0000;
    send_str("<a", 1'b1);
    doc_cur = 15'd2;
    send_char(mtok_pkg::CH_GT, 1'b1, 1'b0);
    send_str("b", 1'b0);
    doc_cur = 15'd3;
    send_char(mtok_pkg::CH_SEMI, 1'b0, 1'b0);

    write_min_length(6'd0);
    send_str("a b", 1'b1);

    write_min_length(6'd63);
    send_word(63);
    send_delim(1'b0);
    send_word(63);
    send_char(mtok_pkg::CH_A, 1'b1, 1'b1);

    write_min_length(6'd1);
    send_random_text(30);
    wait_drained();
    send_random_text(25);
    write_min_length(6'd3);
    send_random_text(30);
    write_min_length(min_t'($urandom_range(2, 10)));
    send_random_text(25);

    wait_drained();
    if (fail_count == 0) begin
      $display("markup_text_word_tokenizer regression: pass");
    end else begin
      $display("markup_text_word_tokenizer regression: fail");
    end
    $finish;
  end

endmodule

// ===== markup_text_word_tokenizer.f =====
rtl/core/mtok_pkg.sv
rtl/core/mtok_queue.sv
rtl/core/mtok_front.sv
rtl/core/mtok_back.sv
rtl/core/markup_text_word_tokenizer.sv
sim/mtok_word_check.sv
sim/tb.sv
